@@ rtl/text_to_int64_parser_macros.svh @@
// Assertion macros for the integer parser.
`ifndef TEXT_TO_INT64_PARSER_MACROS_SVH
`define TEXT_TO_INT64_PARSER_MACROS_SVH

`ifndef SYNTH
`define T2I_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("t2i: invariant violated");
`define T2I_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("t2i: implication violated");
`else
`define T2I_ASSERT_ALWAYS(lbl, cond)
`define T2I_ASSERT_IMPLIES(lbl, ante, cons)
`endif

`endif

@@ rtl/t2i_pkg.sv @@
package t2i_pkg;

  localparam int POS_BITS    = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] MAX_RADIX   = 6'd36;

  localparam logic REG_RADIX = 1'b0;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_DIGITS = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_BAD_BASE  = 2'd3;

  localparam logic [63:0] INT64_MAX_U = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] INT64_MIN_U = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic       first;
    logic       space;
    logic       sign;
    logic       minus;
    logic       zero;
    logic       ex;
    logic       dig_ok;
    logic [5:0] digit;
  } char_class_t;

  typedef struct packed {
    logic                full;
    logic                nonempty;
    logic [QUEUE_AW:0]   level;
  } q_status_t;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    logic [POS_BITS-1:0] r;
    r = (&v) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

@@ rtl/t2i_front.sv @@
module t2i_front (
  input  logic                 in_valid,
  input  logic [7:0]           ch,
  input  logic                 first_char,
  output logic                 in_stall,
  input  t2i_pkg::q_status_t   q_status,
  output logic                 push,
  output t2i_pkg::char_class_t cls
);

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    cls        = '0;
    cls.first  = first_char;
    cls.space  = (ch == 8'h20) || (ch >= 8'd9 && ch <= 8'd13);
    cls.sign   = (ch == 8'h2b) || (ch == 8'h2d);
    cls.minus  = (ch == 8'h2d);
    cls.zero   = (ch == 8'h30);
    cls.ex     = (ch == 8'h78) || (ch == 8'h58);
    if (ch >= 8'h30 && ch <= 8'h39) begin
      cls.dig_ok = 1'b1;
      cls.digit  = 6'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      cls.dig_ok = 1'b1;
      cls.digit  = 6'(ch - 8'h61 + 8'd10);
    end else if (ch >= 8'h41 && ch <= 8'h5a) begin
      cls.dig_ok = 1'b1;
      cls.digit  = 6'(ch - 8'h41 + 8'd10);
    end
  end

endmodule

@@ rtl/t2i_queue.sv @@
module t2i_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  t2i_pkg::char_class_t wr_data,
  input  logic                 pop,
  output t2i_pkg::char_class_t rd_data,
  output t2i_pkg::q_status_t   q_status
);

  t2i_pkg::char_class_t             mem [t2i_pkg::QUEUE_DEPTH];
  logic [t2i_pkg::QUEUE_AW-1:0]     wr_ptr;
  logic [t2i_pkg::QUEUE_AW-1:0]     rd_ptr;
  logic [t2i_pkg::QUEUE_AW:0]       count;

  assign rd_data           = mem[rd_ptr];
  assign q_status.full     = (count == (t2i_pkg::QUEUE_AW+1)'(t2i_pkg::QUEUE_DEPTH));
  assign q_status.nonempty = (count != '0);
  assign q_status.level    = count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/t2i_back.sv @@
module t2i_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [5:0]           radix,
  input  logic                 q_valid,
  input  t2i_pkg::char_class_t q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [63:0]   value,
  output logic [1:0]           status,
  output logic [15:0]          consumed
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_SIGNED = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_XSEEN  = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;

  logic [2:0]                    phase;
  logic                          is_negative;
  logic [63:0]                   accumulator;
  logic                          overflowed;
  logic [5:0]                    active_base;
  logic [t2i_pkg::POS_BITS-1:0]  position;
  logic [t2i_pkg::POS_BITS-1:0]  zero_position;
  logic                          digits_seen;

  logic [2:0]                    e_phase, phase_next;
  logic                          e_neg, is_negative_next;
  logic [63:0]                   e_acc, accumulator_next;
  logic                          e_ovf, overflowed_next;
  logic [5:0]                    e_base, active_base_next;
  logic [t2i_pkg::POS_BITS-1:0]  e_pos, position_next;
  logic [t2i_pkg::POS_BITS-1:0]  e_zpos, zero_position_next;
  logic                          e_seen, digits_seen_next;

  logic                          start, take, emit;
  logic [5:0]                    tb;
  logic [69:0]                   prod;
  logic [63:0]                   limit;
  logic [63:0]                   r_value;
  logic [1:0]                    r_status;
  logic [t2i_pkg::POS_BITS-1:0]  r_count;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    e_phase = phase;
    e_neg   = is_negative;
    e_acc   = accumulator;
    e_ovf   = overflowed;
    e_base  = active_base;
    e_pos   = position;
    e_zpos  = zero_position;
    e_seen  = digits_seen;
    emit     = 1'b0;
    r_value  = '0;
    r_status = t2i_pkg::ST_OK;
    r_count  = '0;
    start    = 1'b0;
    take     = 1'b0;
    tb       = 6'd10;
    prod     = '0;
    limit    = t2i_pkg::INT64_MAX_U;

    if (q_data.first) begin
      e_neg  = 1'b0;
      e_acc  = '0;
      e_ovf  = 1'b0;
      e_pos  = '0;
      e_zpos = '0;
      e_seen = 1'b0;
      e_base = radix;
      if (radix == 6'd1 || radix > t2i_pkg::MAX_RADIX) begin
        e_base   = '0;
        emit     = 1'b1;
        r_status = t2i_pkg::ST_BAD_BASE;
        e_phase  = PH_IDLE;
      end else begin
        e_phase = PH_SPACE;
      end
    end

    phase_next         = e_phase;
    is_negative_next   = e_neg;
    accumulator_next   = e_acc;
    overflowed_next    = e_ovf;
    active_base_next   = e_base;
    position_next      = e_pos;
    zero_position_next = e_zpos;
    digits_seen_next   = e_seen;

    unique case (e_phase)
      PH_SPACE: begin
        if (q_data.space) begin
          position_next = t2i_pkg::sat_inc(e_pos);
        end else if (q_data.sign) begin
          is_negative_next = q_data.minus;
          position_next    = t2i_pkg::sat_inc(e_pos);
          phase_next       = PH_SIGNED;
        end else begin
          start = 1'b1;
        end
      end
      PH_SIGNED: begin
        start = 1'b1;
      end
      PH_ZERO: begin
        if (q_data.ex) begin
          position_next = t2i_pkg::sat_inc(e_pos);
          phase_next    = PH_XSEEN;
        end else begin
          if (e_base == '0) begin
            active_base_next = 6'd8;
          end
          phase_next = PH_DIGITS;
          take       = 1'b1;
        end
      end
      PH_XSEEN: begin
        if (q_data.dig_ok && q_data.digit < 6'd16) begin
          active_base_next = 6'd16;
          accumulator_next = '0;
          phase_next       = PH_DIGITS;
          take             = 1'b1;
        end else begin
          emit       = 1'b1;
          r_count    = t2i_pkg::sat_inc(e_zpos);
          phase_next = PH_IDLE;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
      end
    endcase

    if (start) begin
      if (q_data.zero && (e_base == '0 || e_base == 6'd16)) begin
        zero_position_next = e_pos;
        digits_seen_next   = 1'b1;
        accumulator_next   = '0;
        position_next      = t2i_pkg::sat_inc(e_pos);
        phase_next         = PH_ZERO;
      end else begin
        if (e_base == '0) begin
          active_base_next = 6'd10;
        end
        phase_next = PH_DIGITS;
        take       = 1'b1;
      end
    end

    if (take) begin
      tb = (active_base_next < 6'd2 || active_base_next > t2i_pkg::MAX_RADIX) ?
           6'd10 : active_base_next;
      limit = is_negative_next ? t2i_pkg::INT64_MIN_U : t2i_pkg::INT64_MAX_U;
      prod  = 70'(accumulator_next) * 70'(tb) + 70'(q_data.digit);
      if (q_data.dig_ok && q_data.digit < tb) begin
        if (prod > 70'(limit)) begin
          overflowed_next = 1'b1;
        end else begin
          accumulator_next = prod[63:0];
        end
        digits_seen_next = 1'b1;
        position_next    = t2i_pkg::sat_inc(e_pos);
      end else begin
        emit       = 1'b1;
        phase_next = PH_IDLE;
        if (!e_seen) begin
          r_status = t2i_pkg::ST_NO_DIGITS;
        end else if (e_ovf) begin
          r_value  = limit;
          r_status = t2i_pkg::ST_RANGE;
          r_count  = e_pos;
        end else begin
          r_value  = is_negative_next ? 64'd0 - accumulator_next : accumulator_next;
          r_count  = e_pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      is_negative   <= 1'b0;
      accumulator   <= '0;
      overflowed    <= 1'b0;
      active_base   <= '0;
      position      <= '0;
      zero_position <= '0;
      digits_seen   <= 1'b0;
    end else if (pop) begin
      phase         <= phase_next;
      is_negative   <= is_negative_next;
      accumulator   <= accumulator_next;
      overflowed    <= overflowed_next;
      active_base   <= active_base_next;
      position      <= position_next;
      zero_position <= zero_position_next;
      digits_seen   <= digits_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      value    <= r_value;
      status   <= r_status;
      consumed <= 16'(r_count);
    end
  end

endmodule

@@ rtl/text_to_int64_parser.sv @@
// Streaming text to signed 64-bit integer parser.
// Input channel (in_valid/in_stall): one character per transaction in ch;
// first_char marks the first character of a new text and restarts the parse.
// Output channel (out_valid/out_stall): one transaction per finished parse
// with value, status (ok, no digits, out of range, invalid base) and consumed.
// Radix register at APB address 0, reset value 10; latched at text start.
// Throughput: one character per cycle while the output is not stalled;
// characters that reach the digit phase take one pass through the digit
// unit (a 64x6 multiply-add and overflow compare). The terminating
// character is classified into a 4-entry queue, then executed into the
// output register that drives out_valid.
// Reset: the queue empties, the parser goes idle (characters before a text
// start are dropped) and radix returns to 10.
// Stall: the output register holds its transaction; the execute stage halts,
// the queue fills and in_stall rises once all four entries are used.
`include "text_to_int64_parser_macros.svh"

module text_to_int64_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         ch,
  input  logic               first_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] value,
  output logic [1:0]         status,
  output logic [15:0]        consumed
);

  logic [5:0]           radix;
  logic                 push;
  logic                 pop;
  t2i_pkg::char_class_t cls;
  t2i_pkg::char_class_t q_data;
  t2i_pkg::q_status_t   q_status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == t2i_pkg::REG_RADIX) ? 32'(radix) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= t2i_pkg::RADIX_RESET;
    end else if (psel && penable && pwrite && paddr[2] == t2i_pkg::REG_RADIX) begin
      radix <= pwdata[5:0];
    end
  end

  t2i_front u_front (
    .in_valid   (in_valid),
    .ch         (ch),
    .first_char (first_char),
    .in_stall   (in_stall),
    .q_status   (q_status),
    .push       (push),
    .cls        (cls)
  );

  t2i_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (cls),
    .pop      (pop),
    .rd_data  (q_data),
    .q_status (q_status)
  );

  t2i_back u_back (
    .clk       (clk),
    .rst       (rst),
    .radix     (radix),
    .q_valid   (q_status.nonempty),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status),
    .consumed  (consumed)
  );

  `T2I_ASSERT_ALWAYS(a_queue_bound, q_status.level <= (t2i_pkg::QUEUE_AW+1)'(t2i_pkg::QUEUE_DEPTH))
  `T2I_ASSERT_IMPLIES(a_pop_nonempty, pop, q_status.nonempty)
  `T2I_ASSERT_IMPLIES(a_bad_base_empty, out_valid && status == t2i_pkg::ST_BAD_BASE, value == '0 && consumed == '0)
  `T2I_ASSERT_IMPLIES(a_no_digits_empty, out_valid && status == t2i_pkg::ST_NO_DIGITS, value == '0 && consumed == '0)

endmodule

@@ sim/tb_text_to_int64_parser.sv @@
`timescale 1ns / 100ps

module tb_text_to_int64_parser;

  localparam logic [2:0] RADIX_ADDR       = {t2i_pkg::REG_RADIX, 2'b00};
  localparam int         NOT_A_DIGIT      = 99;
  localparam int         RAND_PHASES      = 12;
  localparam int         ITEMS_PER_PHASE  = 70;
  localparam int         SETTLE_CYCLES    = 16;
  localparam int         DRAIN_GUARD      = 20000;
  localparam int         SHOWN_MISMATCHES = 100;
  localparam longint     TIMEOUT_NS       = 2_000_000;

  localparam logic [5:0] PHASE_RADIX [RAND_PHASES] = '{
    6'd0, 6'd16, 6'd2, 6'd36, 6'd10, 6'd0, 6'd8, 6'd1, 6'd37, 6'd25, 6'd63, 6'd0
  };

  typedef enum logic [2:0] {
    PP_IDLE, PP_SPACE, PP_SIGNED, PP_ZERO, PP_XSEEN, PP_DIGITS
  } parse_phase_e;

  typedef enum logic {ROW_CHAR, ROW_RADIX} row_kind_e;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [15:0] consumed;
  } parse_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } text_char_t;

  typedef struct packed {
    row_kind_e     kind;
    logic [7:0]    ch;
    logic          first;
    logic          pinned;
    parse_result_t res;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         ch;
  logic               first_char;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] value;
  logic [1:0]         status;
  logic [15:0]        consumed;

  parse_result_t results_due[$];
  text_char_t    pending[$];
  plan_row_t     plan[$];
  int            mismatches = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  logic [5:0]    radix_shadow;
  parse_phase_e  parse_phase;
  logic          is_neg;
  logic [63:0]   accum;
  logic          overflow_seen;
  logic [5:0]    text_base;
  logic [15:0]   char_pos;
  logic [15:0]   zero_pos;
  logic          have_digits;

  text_to_int64_parser i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .first_char (first_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .status     (status),
    .consumed   (consumed)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic int digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "z") return int'(c - "a") + 10;
    if (c >= "A" && c <= "Z") return int'(c - "A") + 10;
    return NOT_A_DIGIT;
  endfunction

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
  endfunction

  function automatic logic [15:0] pos_after(input logic [15:0] p);
    return (&p) ? p : p + 16'd1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < SHOWN_MISMATCHES)
      $display("%0t: %s mismatch: got 0x%h, expected 0x%h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic close_parse(input logic [63:0] v, input logic [1:0] s,
                             input logic [15:0] n);
    results_due.push_back('{v, s, n});
    parse_phase = PP_IDLE;
  endtask

  task automatic take_digit(input logic [7:0] c);
    logic [63:0] b, d, lim, cut;
    b = (text_base < 6'd2 || text_base > t2i_pkg::MAX_RADIX) ? 64'd10 : 64'(text_base);
    d = 64'(digit_value(c));
    if (d < b) begin
      lim = is_neg ? t2i_pkg::INT64_MIN_U : t2i_pkg::INT64_MAX_U;
      cut = lim / b;
      if (accum > cut || (accum == cut && d > lim % b)) overflow_seen = 1'b1;
      else accum = accum * b + d;
      have_digits = 1'b1;
      char_pos = pos_after(char_pos);
    end else if (!have_digits) begin
      close_parse('0, t2i_pkg::ST_NO_DIGITS, '0);
    end else if (overflow_seen) begin
      close_parse(is_neg ? t2i_pkg::INT64_MIN_U : t2i_pkg::INT64_MAX_U,
                  t2i_pkg::ST_RANGE, char_pos);
    end else begin
      close_parse(is_neg ? 64'd0 - accum : accum, t2i_pkg::ST_OK, char_pos);
    end
  endtask

  task automatic start_number(input logic [7:0] c);
    if (c == "0" && (text_base == 6'd0 || text_base == 6'd16)) begin
      zero_pos = char_pos;
      have_digits = 1'b1;
      accum = '0;
      char_pos = pos_after(char_pos);
      parse_phase = PP_ZERO;
    end else begin
      if (text_base == 6'd0) text_base = 6'd10;
      parse_phase = PP_DIGITS;
      take_digit(c);
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic f);
    logic bad_base;
    bad_base = 1'b0;
    if (f) begin
      is_neg = 1'b0;
      accum = '0;
      overflow_seen = 1'b0;
      char_pos = '0;
      zero_pos = '0;
      have_digits = 1'b0;
      text_base = radix_shadow;
      if (radix_shadow == 6'd1 || radix_shadow > t2i_pkg::MAX_RADIX) begin
        text_base = '0;
        bad_base = 1'b1;
        close_parse('0, t2i_pkg::ST_BAD_BASE, '0);
      end else begin
        parse_phase = PP_SPACE;
      end
    end
    if (!bad_base) begin
      case (parse_phase)
        PP_SPACE: begin
          if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            char_pos = pos_after(char_pos);
          end else if (c == "+" || c == "-") begin
            is_neg = (c == "-");
            char_pos = pos_after(char_pos);
            parse_phase = PP_SIGNED;
          end else begin
            start_number(c);
          end
        end
        PP_SIGNED: start_number(c);
        PP_ZERO: begin
          if (c == "x" || c == "X") begin
            char_pos = pos_after(char_pos);
            parse_phase = PP_XSEEN;
          end else begin
            if (text_base == 6'd0) text_base = 6'd8;
            parse_phase = PP_DIGITS;
            take_digit(c);
          end
        end
        PP_XSEEN: begin
          if (digit_value(c) < 16) begin
            text_base = 6'd16;
            accum = '0;
            parse_phase = PP_DIGITS;
            take_digit(c);
          end else begin
            close_parse('0, t2i_pkg::ST_OK, pos_after(zero_pos));
          end
        end
        PP_DIGITS: take_digit(c);
        default: ;
      endcase
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_char(input logic [7:0] c, input logic f, input logic pinned,
                           input parse_result_t fixed_res);
    int before_n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    first_char <= f;
    do @(posedge clk); while (in_stall);
    before_n = results_due.size();
    parse_char(c, f);
    if (pinned) begin
      while (results_due.size() > before_n) void'(results_due.pop_back());
      results_due.push_back(fixed_res);
    end
    @(negedge clk);
  endtask

  task automatic write_radix(input logic [5:0] r);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RADIX_ADDR;
    pwdata <= {26'd0, r};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    radix_shadow = r;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_quiet();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (results_due.size() != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_text(input logic [5:0] r);
    logic [7:0]  txt[$];
    logic [7:0]  rev[$];
    logic [7:0]  c;
    logic [63:0] mag;
    logic        negative;
    logic        f;
    int          b, n, d, style;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        f = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
        pending.push_back('{8'($urandom_range(0, 255)), f});
      end
    end else begin
      b = (r >= 6'd2 && r <= t2i_pkg::MAX_RADIX) ? int'(r) : 10;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          d = $urandom_range(0, 5);
          txt.push_back((d == 5) ? 8'h20 : 8'(9 + d));
        end
      end
      d = $urandom_range(0, 3);
      negative = (d == 1);
      if (d == 0) txt.push_back("+");
      else if (d == 1) txt.push_back("-");
      style = 0;
      if (r == 6'd0) style = $urandom_range(0, 2);
      else if (r == 6'd16 && $urandom_range(0, 2) == 0) style = 2;
      if (style == 1) begin
        txt.push_back("0");
        b = 8;
      end else if (style == 2) begin
        txt.push_back("0");
        txt.push_back($urandom_range(0, 1) ? "x" : "X");
        b = 16;
      end
      if (style == 2 && $urandom_range(0, 7) == 0) begin
        // prefix with no hex digit after it
        txt.push_back(8'(($urandom_range(0, 1) ? "g" : "G") + $urandom_range(0, 19)));
      end else begin
        d = $urandom_range(0, 9);
        if (d == 1) begin
          // around the signed limits
          mag = (negative ? t2i_pkg::INT64_MIN_U : t2i_pkg::INT64_MAX_U)
                + 64'($urandom_range(0, 4)) - 64'd2;
          while (mag != 0) begin
            rev.push_back(digit_char(int'(mag % 64'(b))));
            mag = mag / 64'(b);
          end
          while (rev.size() != 0) txt.push_back(rev.pop_back());
        end else if (d != 0) begin
          n = (d == 2) ? $urandom_range(12, 70) : $urandom_range(1, 6);
          for (int i = 0; i < n; i++)
            txt.push_back(digit_char((i == 0 && style == 0 && r == 6'd0) ?
                                     $urandom_range(1, b - 1) : $urandom_range(0, b - 1)));
        end
        d = $urandom_range(0, 9);
        if (d >= 1 && d <= 4) begin
          txt.push_back(8'h00);
        end else if (d >= 5) begin
          do c = 8'($urandom_range(0, 255)); while (digit_value(c) < b);
          txt.push_back(c);
        end
      end
      foreach (txt[i]) pending.push_back('{txt[i], i == 0});
    end
  endtask

  function automatic plan_row_t row_char(input logic [7:0] c, input logic f);
    return '{ROW_CHAR, c, f, 1'b0, '0};
  endfunction

  function automatic plan_row_t row_check(input logic [7:0] c, input logic f,
                                          input logic [63:0] v, input logic [1:0] s,
                                          input logic [15:0] n);
    parse_result_t r;
    r = '{v, s, n};
    return '{ROW_CHAR, c, f, 1'b1, r};
  endfunction

  function automatic plan_row_t row_radix(input logic [5:0] r);
    return '{ROW_RADIX, {2'b00, r}, 1'b0, 1'b0, '0};
  endfunction

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected transaction, value", value, '0);
      end else begin
        want = results_due.pop_front();
        if (value !== want.value) report_mismatch("value", value, want.value);
        if (status !== want.status)
          report_mismatch("status", 64'(status), 64'(want.status));
        if (consumed !== want.consumed)
          report_mismatch("consumed", 64'(consumed), 64'(want.consumed));
      end
    end
  end

  initial begin
    text_char_t item;
    int         sent;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    ch = '0;
    first_char = 1'b0;
    radix_shadow = t2i_pkg::RADIX_RESET;
    parse_phase = PP_IDLE;
    is_neg = 1'b0;
    accum = '0;
    overflow_seen = 1'b0;
    text_base = '0;
    char_pos = '0;
    zero_pos = '0;
    have_digits = 1'b0;

    plan = {
      row_char("7", 1'b0),
      row_char(" ", 1'b1), row_char("-", 1'b0), row_char("1", 1'b0), row_char("2", 1'b0),
      row_check(8'h00, 1'b0, -64'sd12, t2i_pkg::ST_OK, 16'd4),
      row_check(8'hFF, 1'b1, 64'd0, t2i_pkg::ST_NO_DIGITS, 16'd0),
      row_char("9", 1'b1), row_char("8", 1'b1),
      row_check("Z", 1'b0, 64'd8, t2i_pkg::ST_OK, 16'd1),
      row_radix(6'd0),
      row_char("0", 1'b1), row_char("X", 1'b0), row_char("1", 1'b0), row_char("f", 1'b0),
      row_check(8'h00, 1'b0, 64'd31, t2i_pkg::ST_OK, 16'd4),
      row_char("0", 1'b1), row_char("x", 1'b0),
      row_check("g", 1'b0, 64'd0, t2i_pkg::ST_OK, 16'd1),
      row_char("0", 1'b1), row_char("1", 1'b0), row_char("7", 1'b0),
      row_check("9", 1'b0, 64'd15, t2i_pkg::ST_OK, 16'd3),
      row_radix(6'd1),
      row_check("5", 1'b1, 64'd0, t2i_pkg::ST_BAD_BASE, 16'd0),
      row_char("5", 1'b0),
      row_radix(6'd63),
      row_check("a", 1'b1, 64'd0, t2i_pkg::ST_BAD_BASE, 16'd0),
      row_radix(6'd36),
      row_char("Z", 1'b1), row_char("z", 1'b0), row_char(8'h80, 1'b0),
      row_radix(6'd2),
      row_char("1", 1'b1), row_char("0", 1'b0), row_char("2", 1'b0)
    };

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_RADIX) begin
        wait_quiet();
        write_radix(plan[i].ch[5:0]);
      end else begin
        send_char(plan[i].ch, plan[i].first, plan[i].pinned, plan[i].res);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_quiet();
      write_radix(PHASE_RADIX[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 64;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 64;
        end
        default: begin
          send_idle_pct = 12;
          recv_stall_pct = 12;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        queue_text(PHASE_RADIX[p]);
        while (pending.size() != 0) begin
          item = pending.pop_front();
          send_char(item.ch, item.first, 1'b0, '0);
          sent++;
        end
      end
    end

    wait_quiet();
    if (results_due.size() != 0)
      report_mismatch("transactions never seen, count", 64'(results_due.size()), '0);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/t2i_pkg.sv
rtl/t2i_front.sv
rtl/t2i_queue.sv
rtl/t2i_back.sv
rtl/text_to_int64_parser.sv
sim/tb_text_to_int64_parser.sv
